>>> sv/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types and constants of the Cholesky factorizer.
// ----------------------------------------------------------------------------
package chol_pkg;

   localparam int DATA_W     = 32;
   localparam int ACC_W      = 64;
   localparam int ORDER_W    = 4;
   localparam int FAIL_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORDER      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_MODE = 2'd1;

   typedef struct packed {
      logic              start;
      logic              op_div;
      logic [ACC_W-1:0]  operand;
      logic [DATA_W-1:0] divisor;
   } unit_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } unit_rsp_type;

endpackage

>>> sv/cholesky_factorizer.sv
// ----------------------------------------------------------------------------
// cholesky_factorizer
// Fixed-point Cholesky factorization of a symmetric matrix loaded word by word.
// ----------------------------------------------------------------------------
// The req channel loads one matrix element per word (row, col, value)
// while the block is idle. The word with last set is stored, then the
// leading order x order block is factored column by column and req_ready
// stays low until every result word has been taken.
// The csr channel writes order (index 0) and upper_mode (index 1); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. Each factor entry (i,j) is fetched,
// multiply-accumulated over j terms through one multiplier, then taken
// through square root for a pivot or division otherwise, both in the
// shared iterative root/divide unit. Results then leave as n*(n+1)/2
// words; a non-positive pivot gives a single error word instead. A
// stalled receiver holds the result register and the sequencer waits.
// Reset is synchronous: it clears control state and the registers to
// order 8 and lower mode. The matrix store has no reset; only written
// elements may be used.
// ----------------------------------------------------------------------------
module cholesky_factorizer #(
   parameter int MAX_ORDER     = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [$clog2(MAX_ORDER)-1:0]         req_row,
   input  logic [$clog2(MAX_ORDER)-1:0]         req_col,
   input  logic signed [chol_pkg::DATA_W-1:0]   req_value,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [$clog2(MAX_ORDER)-1:0]         rsp_out_row,
   output logic [$clog2(MAX_ORDER)-1:0]         rsp_out_col,
   output logic signed [chol_pkg::DATA_W-1:0]   rsp_factor_value,
   output logic                                 rsp_status,
   output logic [chol_pkg::FAIL_W-1:0]          rsp_fail_column,
   output logic                                 rsp_run_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [chol_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [chol_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int IW    = $clog2(MAX_ORDER);
   localparam int CW    = $clog2(MAX_ORDER + 1);
   localparam int AW    = $clog2(MAX_ORDER * MAX_ORDER);
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int DW    = chol_pkg::DATA_W;
   localparam int XW    = chol_pkg::ACC_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOADA = 4'd1;
   localparam logic [3:0] S_WAITA = 4'd2;
   localparam logic [3:0] S_RD1   = 4'd3;
   localparam logic [3:0] S_RD2   = 4'd4;
   localparam logic [3:0] S_RD3   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_WAITU = 4'd9;
   localparam logic [3:0] S_ERD   = 4'd10;
   localparam logic [3:0] S_EWAIT = 4'd11;
   localparam logic [3:0] S_EHOLD = 4'd12;
   localparam logic [3:0] S_ERR   = 4'd13;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_ORDER) + AW'(c);
   endfunction

   logic [3:0]                  state_ff, state_in;
   logic [chol_pkg::ORDER_W-1:0] order_ff;
   logic                        upper_ff;
   logic [CW-1:0]               i_ff, j_ff, k_ff;
   logic [CW-1:0]               n;
   logic signed [XW-1:0]        acc_ff, acc_in;
   logic signed [DW-1:0]        x_ff, y_ff;
   logic signed [XW-1:0]        prod_ff;
   logic [DW-1:0]               d_ff;
   logic [XW:0]                 diff;

   logic [IW-1:0]               out_row_ff, out_col_ff;
   logic [DW-1:0]               out_value_ff;
   logic                        out_status_ff, out_end_ff;
   logic [chol_pkg::FAIL_W-1:0] out_fail_ff;

   logic                        load_take;
   logic                        load_in_range;
   logic [AW-1:0]               store_rd_addr;
   logic [DW-1:0]               store_rd_data;
   logic                        work_we;
   logic [AW-1:0]               work_rd_addr;
   logic [DW-1:0]               work_rd_data;
   logic                        last_i, last_j;

   chol_pkg::unit_req_type      unit_req;
   chol_pkg::unit_rsp_type      unit_rsp;

   always_comb begin
      if (order_ff == '0) begin
         n = CW'(1);
      end else if (32'(order_ff) > MAX_ORDER) begin
         n = CW'(MAX_ORDER);
      end else begin
         n = CW'(order_ff);
      end
   end

   assign last_i = (i_ff == n - CW'(1));
   assign last_j = (j_ff == n - CW'(1));

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= chol_pkg::ORDER_W'(8);
         upper_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            chol_pkg::CSR_ORDER:      order_ff <= csr_data[chol_pkg::ORDER_W-1:0];
            chol_pkg::CSR_UPPER_MODE: upper_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign load_take = req_valid && req_ready;
   assign load_in_range = (CW'(req_row) < CW'(MAX_ORDER)) && (CW'(req_col) < CW'(MAX_ORDER));

   assign store_rd_addr = upper_ff ? addr_of(j_ff, i_ff) : addr_of(i_ff, j_ff);

   chol_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (load_take && load_in_range),
      .wr_addr (addr_of(CW'(req_row), CW'(req_col))),
      .wr_data (req_value),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   always_comb begin
      unique case (state_ff)
         S_RD2:   work_rd_addr = addr_of(j_ff, k_ff);
         S_ERD:   work_rd_addr = addr_of(i_ff, j_ff);
         default: work_rd_addr = addr_of(i_ff, k_ff);
      endcase
   end

   assign work_we = (state_ff == S_WAITU) && unit_rsp.done;

   chol_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_work (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (addr_of(i_ff, j_ff)),
      .wr_data (unit_rsp.result),
      .rd_addr (work_rd_addr),
      .rd_data (work_rd_data)
   );

   always_comb begin
      unit_req.start   = (state_ff == S_FIN) && !(i_ff == j_ff && (acc_ff[XW-1] || acc_ff == '0));
      unit_req.op_div  = (i_ff != j_ff);
      unit_req.operand = acc_ff;
      unit_req.divisor = d_ff;
   end

   chol_root_div u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   always_comb begin
      diff = {acc_ff[XW-1], acc_ff} - {prod_ff[XW-1], prod_ff};
      if (diff[XW] != diff[XW-1]) begin
         acc_in = diff[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
      end else begin
         acc_in = diff[XW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (load_take && req_last) state_in = S_LOADA;
         S_LOADA: state_in = S_WAITA;
         S_WAITA: state_in = (j_ff == '0) ? S_FIN : S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC:   state_in = (k_ff + CW'(1) == j_ff) ? S_FIN : S_RD1;
         S_FIN:   state_in = unit_req.start ? S_WAITU : S_ERR;
         S_WAITU: begin
            if (unit_rsp.done) state_in = (last_i && last_j) ? S_ERD : S_LOADA;
         end
         S_ERD:   state_in = S_EWAIT;
         S_EWAIT: state_in = S_EHOLD;
         S_EHOLD: begin
            if (rsp_ready) state_in = (last_i && last_j) ? S_IDLE : S_ERD;
         end
         S_ERR:   if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               i_ff <= '0;
               j_ff <= '0;
            end
            S_WAITA: k_ff <= '0;
            S_ACC:   k_ff <= k_ff + CW'(1);
            S_WAITU: begin
               if (unit_rsp.done) begin
                  if (last_i && last_j) begin
                     i_ff <= '0;
                     j_ff <= '0;
                  end else if (!last_i) begin
                     i_ff <= i_ff + CW'(1);
                  end else begin
                     j_ff <= j_ff + CW'(1);
                     i_ff <= j_ff + CW'(1);
                  end
               end
            end
            S_EHOLD: begin
               if (rsp_ready && !(last_i && last_j)) begin
                  if (!last_i) begin
                     i_ff <= i_ff + CW'(1);
                  end else begin
                     j_ff <= j_ff + CW'(1);
                     i_ff <= j_ff + CW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_WAITA: acc_ff <= XW'(signed'(store_rd_data)) <<< FRACTION_BITS;
         S_RD2:   x_ff <= work_rd_data;
         S_RD3:   y_ff <= work_rd_data;
         S_MUL:   prod_ff <= x_ff * y_ff;
         S_ACC:   acc_ff <= acc_in;
         S_WAITU: if (unit_rsp.done && i_ff == j_ff) d_ff <= unit_rsp.result;
         S_FIN: begin
            out_row_ff    <= '0;
            out_col_ff    <= '0;
            out_value_ff  <= '0;
            out_status_ff <= 1'b1;
            out_fail_ff   <= chol_pkg::FAIL_W'(j_ff + CW'(1));
            out_end_ff    <= 1'b1;
         end
         S_EWAIT: begin
            out_row_ff    <= upper_ff ? j_ff[IW-1:0] : i_ff[IW-1:0];
            out_col_ff    <= upper_ff ? i_ff[IW-1:0] : j_ff[IW-1:0];
            out_value_ff  <= work_rd_data;
            out_status_ff <= 1'b0;
            out_fail_ff   <= '0;
            out_end_ff    <= last_i && last_j;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = (state_ff == S_EHOLD) || (state_ff == S_ERR);
   assign rsp_out_row      = out_row_ff;
   assign rsp_out_col      = out_col_ff;
   assign rsp_factor_value = out_value_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_fail_column  = out_fail_ff;
   assign rsp_run_end      = out_end_ff;

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Load accepted while a result word is pending.");

   a_unit_done: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> state_ff == S_WAITU)
      else $error("Root/divide result arrived outside its wait state.");

   a_err_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_run_end && state_ff == S_ERR))
      else $error("Error word without run end.");

   a_emit_tri: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EHOLD) |-> (i_ff >= j_ff && i_ff < n))
      else $error("Emitted index outside the triangle.");
`endif

endmodule

>>> sv/chol_ram.sv
// ----------------------------------------------------------------------------
// chol_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module chol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/chol_root_div.sv
// ----------------------------------------------------------------------------
// chol_root_div
// Iterative unit for the floor square root of a 64-bit value (two bits a
// cycle) and the truncating division of a 64-bit value by a positive 32-bit
// pivot (one bit a cycle), both saturated to 32 bits.
// ----------------------------------------------------------------------------
module chol_root_div (
   input  logic                  clock,
   input  logic                  reset,
   input  chol_pkg::unit_req_type req,
   output chol_pkg::unit_rsp_type rsp
);

   logic                         busy_ff;
   logic                         fin_ff;
   logic                         op_div_ff;
   logic                         neg_ff;
   logic [5:0]                   cnt_ff;
   logic [chol_pkg::ACC_W-1:0]   x_ff;
   logic [chol_pkg::ACC_W-1:0]   q_ff;
   logic [35:0]                  rem_ff;
   logic [chol_pkg::DATA_W-1:0]  den_ff;

   logic [35:0]                  sq_rem_t;
   logic [35:0]                  sq_trial;
   logic [32:0]                  dv_rem_t;
   logic [chol_pkg::DATA_W-1:0]  result;

   always_comb begin
      sq_rem_t = {rem_ff[33:0], x_ff[63:62]};
      sq_trial = {2'b00, q_ff[31:0], 2'b01};
      dv_rem_t = {rem_ff[31:0], x_ff[63]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         fin_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         op_div_ff <= req.op_div;
         rem_ff    <= '0;
         q_ff      <= '0;
         den_ff    <= req.divisor;
         if (req.op_div) begin
            neg_ff <= req.operand[63];
            x_ff   <= req.operand[63] ? (~req.operand + 64'd1) : req.operand;
            cnt_ff <= 6'd63;
         end else begin
            neg_ff <= 1'b0;
            x_ff   <= req.operand;
            cnt_ff <= 6'd31;
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (op_div_ff) begin
            x_ff <= {x_ff[62:0], 1'b0};
            if (dv_rem_t >= {1'b0, den_ff}) begin
               rem_ff <= {3'b000, dv_rem_t - {1'b0, den_ff}};
               q_ff   <= {q_ff[62:0], 1'b1};
            end else begin
               rem_ff <= {3'b000, dv_rem_t};
               q_ff   <= {q_ff[62:0], 1'b0};
            end
         end else begin
            x_ff <= {x_ff[61:0], 2'b00};
            if (sq_rem_t >= sq_trial) begin
               rem_ff <= sq_rem_t - sq_trial;
               q_ff   <= {q_ff[62:0], 1'b1};
            end else begin
               rem_ff <= sq_rem_t;
               q_ff   <= {q_ff[62:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      if (!op_div_ff) begin
         result = q_ff[31] ? 32'h7FFF_FFFF : q_ff[31:0];
      end else if (!neg_ff) begin
         result = (q_ff[63:31] != '0) ? 32'h7FFF_FFFF : q_ff[31:0];
      end else if (q_ff[63:32] != '0 || (q_ff[31] && q_ff[30:0] != '0)) begin
         result = 32'h8000_0000;
      end else begin
         result = ~q_ff[31:0] + 32'd1;
      end
   end

   assign rsp.done   = fin_ff;
   assign rsp.result = result;

endmodule
